@@ rtl/crg_pkg.sv @@
package crg_pkg;

    // Field and register widths
    localparam int C_IDX_W     = 24;
    localparam int C_SIDE_W    = 13;
    localparam int C_PIX_W     = 12;
    localparam int C_VEC_W     = 48;
    localparam int C_LANE_W    = 16;
    localparam int C_DIR_W     = 16;
    localparam int C_CFG_IDX_W = 3;

    // Image side limits and reset values
    localparam int C_MAX_SIDE   = 4096;
    localparam int C_WIDTH_RST  = 640;
    localparam int C_HEIGHT_RST = 480;

    // Normalised screen coordinate, Q.20, quotient carries one extra bit
    localparam int C_NC_FRAC = 20;
    localparam int C_NC_W    = C_NC_FRAC + 1;
    localparam int C_NC_HALF = 1 << (C_NC_FRAC - 1);

    // Direction datapath
    localparam int C_PROD_W  = C_NC_W + C_LANE_W;
    localparam int C_DSUM_W  = C_PROD_W + 1;
    localparam int C_FRM_W   = 40;
    localparam int C_MAG_W   = 30;
    localparam int C_SQ_W    = 2 * C_MAG_W;
    localparam int C_SUM_W   = C_SQ_W + 2;
    localparam int C_RT_W    = 64;
    localparam int C_LEN_W   = 31;
    localparam int C_NRM_TOP = 32;

    // Iteration steps handled per pipeline stage
    localparam int C_D1_STEP = 4;
    localparam int C_D2_STEP = 3;
    localparam int C_RT_STEP = 2;
    localparam int C_D3_STEP = 2;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        REG_POSITION = 3'd0,
        REG_UP       = 3'd1,
        REG_FORWARD  = 3'd2,
        REG_RIGHT    = 3'd3,
        REG_WIDTH    = 3'd4,
        REG_HEIGHT   = 3'd5
    } t_cfg_reg;

    // Pixel index divider: remainder and shared dividend/quotient word
    typedef struct packed {
        logic [C_SIDE_W-1:0] rem;
        logic [C_IDX_W-1:0]  dq;
    } t_d1;

    // Screen coordinate divider
    typedef struct packed {
        logic [C_SIDE_W:0] rem;
        logic [C_NC_W-1:0] dq;
    } t_d2;

    // Unit vector divider
    typedef struct packed {
        logic [C_LEN_W:0]   rem;
        logic [C_DIR_W-1:0] dq;
    } t_d3;

    // Magnitude normaliser
    typedef struct packed {
        logic [C_FRM_W-1:0]      m;
        logic [2:0][C_FRM_W-1:0] mag;
    } t_nrm;

    // Square root, radicand remainder and partial root
    typedef struct packed {
        logic [C_RT_W-1:0] x;
        logic [C_RT_W-1:0] r;
    } t_rt;

    // Clamp a side register to the usable range
    function automatic logic [C_SIDE_W-1:0] f_side(input logic [C_SIDE_W-1:0] r);
        logic [C_SIDE_W-1:0] v;
        v = r;
        if (r < C_SIDE_W'(2)) begin
            v = C_SIDE_W'(2);
        end else if (32'(r) > C_MAX_SIDE) begin
            v = C_SIDE_W'(C_MAX_SIDE);
        end
        return v;
    endfunction

    // Restoring division steps for index / width
    function automatic t_d1 f_div1(input t_d1 a, input logic [C_SIDE_W-1:0] dvs);
        t_d1               v;
        logic [C_SIDE_W:0] t;
        v = a;
        for (int i = 0; i < C_D1_STEP; i++) begin
            t    = {v.rem, v.dq[C_IDX_W-1]};
            v.dq = {v.dq[C_IDX_W-2:0], 1'b0};
            if (t >= {1'b0, dvs}) begin
                t       = t - {1'b0, dvs};
                v.dq[0] = 1'b1;
            end
            v.rem = t[C_SIDE_W-1:0];
        end
        return v;
    endfunction

    // Restoring division steps for the screen coordinate
    function automatic t_d2 f_div2(input t_d2 a, input logic [C_SIDE_W:0] dvs);
        t_d2                 v;
        logic [C_SIDE_W+1:0] t;
        v = a;
        for (int i = 0; i < C_D2_STEP; i++) begin
            t    = {v.rem, v.dq[C_NC_W-1]};
            v.dq = {v.dq[C_NC_W-2:0], 1'b0};
            if (t >= {1'b0, dvs}) begin
                t       = t - {1'b0, dvs};
                v.dq[0] = 1'b1;
            end
            v.rem = t[C_SIDE_W:0];
        end
        return v;
    endfunction

    // Restoring division steps for component / length
    function automatic t_d3 f_div3(input t_d3 a, input logic [C_LEN_W:0] dvs);
        t_d3                v;
        logic [C_LEN_W+1:0] t;
        v = a;
        for (int i = 0; i < C_D3_STEP; i++) begin
            t    = {v.rem, v.dq[C_DIR_W-1]};
            v.dq = {v.dq[C_DIR_W-2:0], 1'b0};
            if (t >= {1'b0, dvs}) begin
                t       = t - {1'b0, dvs};
                v.dq[0] = 1'b1;
            end
            v.rem = t[C_LEN_W:0];
        end
        return v;
    endfunction

    // One left shift step of the common normalisation
    function automatic t_nrm f_nrm(input t_nrm a, input int s);
        t_nrm v;
        v = a;
        if ((a.m >> (C_FRM_W - s)) == '0) begin
            v.m = a.m << s;
            for (int k = 0; k < 3; k++) begin
                v.mag[k] = a.mag[k] << s;
            end
        end
        return v;
    endfunction

    // Digit-by-digit square root steps, base is the first step number
    function automatic t_rt f_root(input t_rt a, input int base);
        t_rt               v;
        logic [C_RT_W-1:0] b;
        v = a;
        for (int i = 0; i < C_RT_STEP; i++) begin
            b = C_RT_W'(1) << (C_RT_W - 2 - 2 * (base + i));
            if (v.x >= v.r + b) begin
                v.x = v.x - (v.r + b);
                v.r = (v.r >> 1) + b;
            end else begin
                v.r = v.r >> 1;
            end
        end
        return v;
    endfunction

endpackage

@@ rtl/camera_ray_generator.sv @@
// Pinhole camera primary ray generator. While the output is not stalled, one pixel
// index word is taken per clock and one ray word leaves per clock. The pipeline has 49
// register stages, and its depth is set by the 32-step square root unit together with
// the pipelined index, coordinate and length dividers. A stall on the output freezes the
// whole pipeline and is passed straight back as o_stall, so nothing is dropped
// or repeated. The configuration port is always ready; registers are to be written only
// while no word is in flight. The camera position register is accepted for compatibility
// but does not affect any output, as the origin cancels out of the direction. A zero
// direction vector returns a zero direction with o_zero_length set.
module camera_ray_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [crg_pkg::C_IDX_W-1:0]         i_pixel_index,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [crg_pkg::C_PIX_W-1:0]         o_pixel_column,
    output logic [crg_pkg::C_PIX_W-1:0]         o_pixel_row,
    output logic signed [crg_pkg::C_DIR_W-1:0]  o_dir_x,
    output logic signed [crg_pkg::C_DIR_W-1:0]  o_dir_y,
    output logic signed [crg_pkg::C_DIR_W-1:0]  o_dir_z,
    output logic                                o_zero_length,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [crg_pkg::C_CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [crg_pkg::C_VEC_W-1:0]         i_cfg_data
);

    // Stage map
    localparam int P_D1  = 1;
    localparam int N_D1  = crg_pkg::C_IDX_W / crg_pkg::C_D1_STEP;
    localparam int P_CL  = P_D1 + N_D1;
    localparam int P_D2  = P_CL + 1;
    localparam int N_D2  = crg_pkg::C_NC_W / crg_pkg::C_D2_STEP;
    localparam int P_MUL = P_D2 + N_D2;
    localparam int P_SUM = P_MUL + 1;
    localparam int P_ABS = P_SUM + 1;
    localparam int P_MAX = P_ABS + 1;
    localparam int P_NRM = P_MAX + 1;
    localparam int N_NRM = 3;
    localparam int P_SQR = P_NRM + N_NRM;
    localparam int P_ADD = P_SQR + 1;
    localparam int P_RT  = P_ADD + 1;
    localparam int N_RT  = (crg_pkg::C_RT_W / 2) / crg_pkg::C_RT_STEP;
    localparam int P_D3  = P_RT + N_RT;
    localparam int N_D3  = crg_pkg::C_DIR_W / crg_pkg::C_D3_STEP;
    localparam int P_OUT = P_D3 + N_D3;
    localparam int NST   = P_OUT + 1;

    localparam int SW = crg_pkg::C_SIDE_W;
    localparam int LW = crg_pkg::C_LANE_W;

    // Configuration
    logic [crg_pkg::C_VEC_W-1:0] r_up;
    logic [crg_pkg::C_VEC_W-1:0] r_fwd;
    logic [crg_pkg::C_VEC_W-1:0] r_rgt;
    logic [SW-1:0]               r_width;
    logic [SW-1:0]               r_height;

    // Pipeline
    logic [NST-1:0]                           r_vld;
    logic                                     w_adv;
    logic [crg_pkg::C_IDX_W-1:0]              r_idx;
    crg_pkg::t_d1                             r_d1 [P_D1:P_CL-1];
    logic [SW-1:0]                            r_col [P_CL:P_OUT];
    logic [SW-1:0]                            r_row [P_CL:P_OUT];
    crg_pkg::t_d2                             r_d2x [P_D2:P_MUL-1];
    crg_pkg::t_d2                             r_d2y [P_D2:P_MUL-1];
    logic [2:0][crg_pkg::C_PROD_W-1:0]        r_px;
    logic [2:0][crg_pkg::C_PROD_W-1:0]        r_py;
    logic [2:0][crg_pkg::C_DSUM_W-1:0]        r_d;
    logic [2:0][crg_pkg::C_FRM_W-1:0]         r_mag_a;
    logic [2:0]                               r_neg [P_ABS:P_OUT-1];
    logic                                     r_zero [P_MAX:P_OUT-1];
    crg_pkg::t_nrm                            r_nrm [P_MAX:P_SQR-1];
    logic [2:0][crg_pkg::C_SQ_W-1:0]          r_sq;
    logic [2:0][crg_pkg::C_MAG_W-1:0]         r_mf [P_SQR:P_D3-1];
    logic [crg_pkg::C_SUM_W-1:0]              r_sum;
    crg_pkg::t_rt                             r_rt [P_RT:P_D3-1];
    crg_pkg::t_d3                             r_d3 [P_D3:P_OUT-1][3];
    logic [crg_pkg::C_LEN_W-1:0]              r_len [P_D3:P_OUT-1];
    logic [2:0][crg_pkg::C_DIR_W-1:0]         r_dir;
    logic                                     r_zl;

    // Combinational terms
    logic [SW-1:0]                     n_side_w;
    logic [SW-1:0]                     n_side_h;
    logic [SW-1:0]                     n_den_w;
    logic [SW-1:0]                     n_den_h;
    logic [SW:0]                       n_div_x;
    logic [SW:0]                       n_div_y;
    logic signed [crg_pkg::C_NC_W-1:0] n_nx;
    logic signed [crg_pkg::C_NC_W-1:0] n_ny;
    logic signed [LW-1:0]              n_rgt [3];
    logic signed [LW-1:0]              n_upl [3];
    logic signed [crg_pkg::C_PROD_W-1:0] n_px [3];
    logic signed [crg_pkg::C_PROD_W-1:0] n_py [3];
    logic signed [crg_pkg::C_DSUM_W-1:0] n_d [3];
    logic [crg_pkg::C_DSUM_W-1:0]      n_mag [3];
    logic [crg_pkg::C_FRM_W-1:0]       n_m01;
    logic [crg_pkg::C_FRM_W-1:0]       n_m;
    logic [crg_pkg::C_MAG_W-1:0]       n_mf [3];
    logic [crg_pkg::C_LEN_W-1:0]       n_len;
    logic [crg_pkg::C_MAG_W+crg_pkg::C_DIR_W-1:0] n_n3 [3];

    // Handshake: the whole pipeline moves unless a finished word is held
    assign w_adv       = !r_vld[P_OUT] || !i_stall;
    assign o_stall     = !w_adv;
    assign o_valid     = r_vld[P_OUT];
    assign o_cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up     <= '0;
            r_fwd    <= '0;
            r_rgt    <= '0;
            r_width  <= SW'(crg_pkg::C_WIDTH_RST);
            r_height <= SW'(crg_pkg::C_HEIGHT_RST);
        end else if (i_cfg_valid) begin
            unique case (crg_pkg::t_cfg_reg'(i_cfg_index))
                crg_pkg::REG_POSITION: begin
                    // origin does not enter the direction
                end
                crg_pkg::REG_UP:      r_up     <= i_cfg_data;
                crg_pkg::REG_FORWARD: r_fwd    <= i_cfg_data;
                crg_pkg::REG_RIGHT:   r_rgt    <= i_cfg_data;
                crg_pkg::REG_WIDTH:   r_width  <= i_cfg_data[SW-1:0];
                crg_pkg::REG_HEIGHT:  r_height <= i_cfg_data[SW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Side clamps, divisors, lanes and stage arithmetic
    always_comb begin
        n_side_w = crg_pkg::f_side(r_width);
        n_side_h = crg_pkg::f_side(r_height);
        n_den_w  = n_side_w - SW'(1);
        n_den_h  = n_side_h - SW'(1);
        n_div_x  = {n_den_w, 1'b0};
        n_div_y  = {n_den_h, 1'b0};
        n_nx = $signed(r_d2x[P_MUL-1].dq - crg_pkg::C_NC_W'(crg_pkg::C_NC_HALF));
        n_ny = $signed(r_d2y[P_MUL-1].dq - crg_pkg::C_NC_W'(crg_pkg::C_NC_HALF));
        for (int k = 0; k < 3; k++) begin
            n_rgt[k] = $signed(r_rgt[LW*k +: LW]);
            n_upl[k] = $signed(r_up[LW*k +: LW]);
            n_px[k]  = n_nx * n_rgt[k];
            n_py[k]  = n_ny * n_upl[k];
            n_d[k]   = $signed(r_px[k]) + $signed(r_py[k])
                     + $signed({r_fwd[LW*k +: LW], crg_pkg::C_NC_FRAC'(0)});
            n_mag[k] = r_d[k][crg_pkg::C_DSUM_W-1] ? (crg_pkg::C_DSUM_W'(0) - r_d[k]) : r_d[k];
            n_mf[k]  = r_nrm[P_SQR-1].mag[k][crg_pkg::C_FRM_W-1 -: crg_pkg::C_MAG_W];
        end
        n_m01 = (r_mag_a[0] >= r_mag_a[1]) ? r_mag_a[0] : r_mag_a[1];
        n_m   = (n_m01 >= r_mag_a[2]) ? n_m01 : r_mag_a[2];
        n_len = r_rt[P_D3-1].r[crg_pkg::C_LEN_W-1:0];
        // component * 2^15 + length, split into initial remainder and low bits
        for (int k = 0; k < 3; k++) begin
            n_n3[k] = {1'b0, r_mf[P_D3-1][k], 15'd0} + {15'd0, n_len};
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_idx <= i_pixel_index;

            // index / width
            r_d1[P_D1] <= crg_pkg::f_div1(crg_pkg::t_d1'{rem: '0, dq: r_idx}, n_side_w);
            for (int s = P_D1 + 1; s < P_CL; s++) begin
                r_d1[s] <= crg_pkg::f_div1(r_d1[s-1], n_side_w);
            end

            // column, row saturated at the last line
            r_col[P_CL] <= r_d1[P_CL-1].rem;
            if (r_d1[P_CL-1].dq > crg_pkg::C_IDX_W'(n_den_h)) begin
                r_row[P_CL] <= n_den_h;
            end else begin
                r_row[P_CL] <= r_d1[P_CL-1].dq[SW-1:0];
            end
            for (int s = P_CL + 1; s <= P_OUT; s++) begin
                r_col[s] <= r_col[s-1];
                r_row[s] <= r_row[s-1];
            end

            // coord / (side-1), rounded half up
            r_d2x[P_D2] <= crg_pkg::f_div2(crg_pkg::t_d2'{rem: {1'b0, r_col[P_CL]},
                dq: crg_pkg::C_NC_W'(n_den_w)}, n_div_x);
            r_d2y[P_D2] <= crg_pkg::f_div2(crg_pkg::t_d2'{rem: {1'b0, r_row[P_CL]},
                dq: crg_pkg::C_NC_W'(n_den_h)}, n_div_y);
            for (int s = P_D2 + 1; s < P_MUL; s++) begin
                r_d2x[s] <= crg_pkg::f_div2(r_d2x[s-1], n_div_x);
                r_d2y[s] <= crg_pkg::f_div2(r_d2y[s-1], n_div_y);
            end

            // products, direction sum, magnitude
            for (int k = 0; k < 3; k++) begin
                r_px[k]    <= n_px[k];
                r_py[k]    <= n_py[k];
                r_d[k]     <= n_d[k];
                r_mag_a[k] <= {2'b00, n_mag[k]};
            end
            r_neg[P_ABS] <= {r_d[2][crg_pkg::C_DSUM_W-1], r_d[1][crg_pkg::C_DSUM_W-1],
                             r_d[0][crg_pkg::C_DSUM_W-1]};
            for (int s = P_ABS + 1; s < P_OUT; s++) begin
                r_neg[s] <= r_neg[s-1];
            end

            // largest magnitude, zero test
            r_nrm[P_MAX]  <= crg_pkg::t_nrm'{m: n_m, mag: r_mag_a};
            r_zero[P_MAX] <= (r_mag_a == '0);
            for (int s = P_MAX + 1; s < P_OUT; s++) begin
                r_zero[s] <= r_zero[s-1];
            end

            // common normalisation, two shift steps a stage
            for (int j = 0; j < N_NRM; j++) begin
                r_nrm[P_NRM+j] <= crg_pkg::f_nrm(crg_pkg::f_nrm(r_nrm[P_NRM+j-1],
                    crg_pkg::C_NRM_TOP >> (2 * j)), crg_pkg::C_NRM_TOP >> (2 * j + 1));
            end

            // squares and their sum
            for (int k = 0; k < 3; k++) begin
                r_sq[k]       <= n_mf[k] * n_mf[k];
                r_mf[P_SQR][k] <= n_mf[k];
            end
            for (int s = P_SQR + 1; s < P_D3; s++) begin
                r_mf[s] <= r_mf[s-1];
            end
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];

            // floor square root
            r_rt[P_RT] <= crg_pkg::f_root(crg_pkg::t_rt'{x: crg_pkg::C_RT_W'(r_sum), r: '0}, 0);
            for (int j = 1; j < N_RT; j++) begin
                r_rt[P_RT+j] <= crg_pkg::f_root(r_rt[P_RT+j-1], j * crg_pkg::C_RT_STEP);
            end

            // component / length in Q.14, rounded half away from zero
            r_len[P_D3] <= n_len;
            for (int s = P_D3 + 1; s < P_OUT; s++) begin
                r_len[s] <= r_len[s-1];
            end
            for (int k = 0; k < 3; k++) begin
                r_d3[P_D3][k] <= crg_pkg::f_div3(crg_pkg::t_d3'{
                    rem: {2'b00, n_n3[k][crg_pkg::C_MAG_W+crg_pkg::C_DIR_W-1:crg_pkg::C_DIR_W]},
                    dq: n_n3[k][crg_pkg::C_DIR_W-1:0]}, {n_len, 1'b0});
                for (int s = P_D3 + 1; s < P_OUT; s++) begin
                    r_d3[s][k] <= crg_pkg::f_div3(r_d3[s-1][k], {r_len[s-1], 1'b0});
                end
            end

            // output word
            for (int k = 0; k < 3; k++) begin
                if (r_zero[P_OUT-1]) begin
                    r_dir[k] <= '0;
                end else if (r_neg[P_OUT-1][k]) begin
                    r_dir[k] <= crg_pkg::C_DIR_W'(0) - r_d3[P_OUT-1][k].dq;
                end else begin
                    r_dir[k] <= r_d3[P_OUT-1][k].dq;
                end
            end
            r_zl <= r_zero[P_OUT-1];
        end
    end

    assign o_pixel_column = r_col[P_OUT][crg_pkg::C_PIX_W-1:0];
    assign o_pixel_row    = r_row[P_OUT][crg_pkg::C_PIX_W-1:0];
    assign o_dir_x        = $signed(r_dir[0]);
    assign o_dir_y        = $signed(r_dir[1]);
    assign o_dir_z        = $signed(r_dir[2]);
    assign o_zero_length  = r_zl;

    // Checks
    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_length |-> o_dir_x == 0 && o_dir_y == 0 && o_dir_z == 0)
        else $error("zero length word with non-zero direction");

    a_unit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_zero_length |->
            o_dir_x >= 16'sd9000 || o_dir_x <= -16'sd9000 ||
            o_dir_y >= 16'sd9000 || o_dir_y <= -16'sd9000 ||
            o_dir_z >= 16'sd9000 || o_dir_z <= -16'sd9000)
        else $error("direction too short for a unit vector");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            o_dir_x <= 16'sd16384 && o_dir_x >= -16'sd16384 &&
            o_dir_y <= 16'sd16384 && o_dir_y >= -16'sd16384 &&
            o_dir_z <= 16'sd16384 && o_dir_z >= -16'sd16384)
        else $error("direction component beyond one");

    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

endmodule
